@@ sv/pcpd_pkg.sv @@
package pcpd_pkg;

    localparam logic [7:0] TERMINATOR_BYTE = 8'd255;

    localparam logic [0:0] CFG_PICTURE_WIDTH  = 1'd0;
    localparam logic [0:0] CFG_PICTURE_HEIGHT = 1'd1;

    localparam logic [15:0] PICTURE_WIDTH_RESET  = 16'd64;
    localparam logic [15:0] PICTURE_HEIGHT_RESET = 16'd128;

    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_TOP    = 6'b000010,
        PH_LEN    = 6'b000100,
        PH_PAD1   = 6'b001000,
        PH_PIXELS = 6'b010000,
        PH_PAD2   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] column_index;
        logic [7:0]  data_byte;
    } pcpd_item_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] pixel_column;
        logic [8:0]  pixel_row;
        logic [7:0]  palette_index;
        logic        end_of_column;
    } pcpd_result_t;

endpackage

@@ sv/pcpd_parser.sv @@
module pcpd_parser
    import pcpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  pcpd_item_t   item,
    input  logic [15:0]  picture_width,
    input  logic [15:0]  picture_height,
    output pcpd_result_t result
);

    phase_t      phase_reg, phase_next;
    logic [15:0] column_reg, column_next;
    logic [7:0]  top_row_reg, top_row_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  done_reg, done_next;

    logic [8:0]  row;
    logic        visible;

    assign row     = {1'b0, top_row_reg} + {1'b0, done_reg};
    assign visible = (column_reg < picture_width) && ({7'd0, row} < picture_height);

    always_comb
    begin
        phase_next   = phase_reg;
        column_next  = column_reg;
        top_row_next = top_row_reg;
        length_next  = length_reg;
        done_next    = done_reg;

        result.valid         = 1'b0;
        result.pixel_column  = column_reg;
        result.pixel_row     = row;
        result.palette_index = item.data_byte;
        result.end_of_column = 1'b0;

        if (item.kind == KIND_BEGIN)
        begin
            column_next  = item.column_index;
            top_row_next = 8'd0;
            length_next  = 8'd0;
            done_next    = 8'd0;
            phase_next   = PH_TOP;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_TOP:
                begin
                    if (item.data_byte == TERMINATOR_BYTE)
                    begin
                        result.valid         = 1'b1;
                        result.pixel_row     = 9'd0;
                        result.palette_index = 8'd0;
                        result.end_of_column = 1'b1;
                        phase_next           = PH_IDLE;
                    end
                    else
                    begin
                        top_row_next = item.data_byte;
                        phase_next   = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    length_next = item.data_byte;
                    done_next   = 8'd0;
                    phase_next  = PH_PAD1;
                end
                PH_PAD1:
                begin
                    phase_next = (length_reg == 8'd0) ? PH_PAD2 : PH_PIXELS;
                end
                PH_PIXELS:
                begin
                    done_next    = done_reg + 8'd1;
                    result.valid = visible;
                    if (done_next >= length_reg)
                    begin
                        phase_next = PH_PAD2;
                    end
                end
                PH_PAD2:
                begin
                    phase_next = PH_TOP;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            column_reg  <= 16'd0;
            top_row_reg <= 8'd0;
            length_reg  <= 8'd0;
            done_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            column_reg  <= column_next;
            top_row_reg <= top_row_next;
            length_reg  <= length_next;
            done_reg    <= done_next;
        end
    end

endmodule

@@ sv/patch_column_post_decoder.sv @@
// Column post decoder for a column-based picture.
// Input stream (s_axis): tuser = kind (0 begin column, 1 data byte); on a begin
// beat tdata[15:0] names the column, on a data beat tdata[23:16] is one raw
// column byte. A column is a series of posts (top row, length, pad, pixels,
// pad) closed by the top-row byte 255.
// Output stream (m_axis): one beat per pixel inside the configured picture,
// tdata = {pad, palette_index, pixel_row, pixel_column}; the terminator gives a
// beat with tlast high, row and palette zero. Other bytes give no beat.
// Config channel: cfg_index 0 = picture_width, 1 = picture_height, written
// with cfg_valid/cfg_ready; cfg_ready is always high. Write only while idle.
// A result reaches m_axis via the input register, then the result register.
// Throughput: one input beat per cycle while the receiver does not stall, set
// by the single-step parser between the two registers.
// Reset clears the parser to idle (data before a begin is ignored), empties
// both registers and loads width 64 and height 128.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more beat before s_axis_tready falls.
module patch_column_post_decoder
    import pcpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // column_index[15:0], data_byte[23:16]
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // pixel_column[15:0], pixel_row[24:16],
                                        // palette_index[32:25], zero[39:33]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0]  width_reg;
    logic [15:0]  height_reg;
    logic         in_valid_reg;
    pcpd_item_t   in_reg;
    logic         out_valid_reg;
    pcpd_result_t out_reg;
    pcpd_result_t result;
    logic         out_free;
    logic         step;
    logic         s_accept;

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign step          = in_valid_reg && out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= PICTURE_WIDTH_RESET;
            height_reg <= PICTURE_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PICTURE_WIDTH:  width_reg  <= cfg_data;
                CFG_PICTURE_HEIGHT: height_reg <= cfg_data;
                default:            width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_reg.kind         <= s_axis_tuser;
            in_reg.column_index <= s_axis_tdata[15:0];
            in_reg.data_byte    <= s_axis_tdata[23:16];
        end
    end

    pcpd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .item           (in_reg),
        .picture_width  (width_reg),
        .picture_height (height_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= result.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.valid)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.palette_index, out_reg.pixel_row,
                            out_reg.pixel_column};
    assign m_axis_tlast  = out_reg.end_of_column;

endmodule

@@ sv/pcpd_checker.sv @@
module pcpd_checker
    import pcpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        m_axis_tlast
);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
        else $error("output pad bits not zero");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[32:16] == 17'd0)
        else $error("end-of-column beat carries row or palette");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("output beat without input beat two cycles earlier");

endmodule

bind patch_column_post_decoder pcpd_checker u_pcpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
